// ----- hdl/vrdb_pkg.sv -----
// vrdb_pkg: shared widths, latencies, status codes, sideband type and the
// mantissa table generator for the voltage ratio to decibels pipeline
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package vrdb_pkg;

  // normalized operand: positive value below 2^31
  localparam int unsigned NORM_W    = 31;
  localparam int unsigned E_W       = 5;
  localparam int unsigned FRAC_BITS = 28;
  // table entries run up to 1.0 in q.28, so one bit more
  localparam int unsigned TBL_W     = FRAC_BITS + 1;
  // log2 value: exponent up to 30 plus a q.28 mantissa
  localparam int unsigned LOG_W     = 33;

  localparam int unsigned LOG_LAT    = 5;
  localparam int unsigned SCALE_LAT  = 3;
  localparam int unsigned PIPE_DEPTH = LOG_LAT + SCALE_LAT;

  // round(2*log10(2) * 2^30)
  localparam int unsigned K_W = 30;
  localparam logic [K_W-1:0] K_LOG10_2X2 = 30'd646456993;

  localparam int unsigned LEVEL_W = 21;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX     = 21'sh0FFFFF;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN     = 21'sh100000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_ZERO_IN = -21'sd983040;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NEGATIVE = 2'd2,
    ST_BAD_REF  = 2'd3
  } status_e;

  typedef struct packed {
    logic    valid;
    logic    last;
    status_e status;
  } side_t;

  // log2(1 + k/2^bits) in q.28 by repeated squaring with truncation
  function automatic logic [TBL_W-1:0] tbl_entry(input int unsigned k,
                                                 input int unsigned bits);
    logic [63:0]          m;
    logic [FRAC_BITS-1:0] r;
    m = 64'((64'd1 << bits) + 64'(k)) << (30 - bits);
    r = '0;
    if (k >= (32'd1 << bits)) begin
      return TBL_W'(1) << FRAC_BITS;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        m = m >> 1;
      end
    end
    return TBL_W'(r);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/vrdb_log2.sv -----
// vrdb_log2: five stage base-2 logarithm of a positive 31-bit value,
// leading one detect, normalize, table read, interpolate, sum
// depends on: vrdb_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrdb_log2 #(
  parameter int unsigned LOG_TABLE_BITS = 6
) (
  input  wire                          clk_i,
  input  wire  [vrdb_pkg::NORM_W-1:0]  x_i,
  output logic [vrdb_pkg::LOG_W-1:0]   log_o
);
  import vrdb_pkg::*;

  localparam int unsigned TBL_N  = 1 << LOG_TABLE_BITS;
  localparam int unsigned IDX_W  = LOG_TABLE_BITS + 1;
  localparam int unsigned REM_W  = NORM_W - LOG_TABLE_BITS;
  localparam int unsigned PROD_W = TBL_W + REM_W;

  // constant mantissa table
  logic [TBL_W-1:0] tbl [TBL_N+1];
  for (genvar k = 0; k <= TBL_N; k++) begin : g_tbl
    localparam logic [TBL_W-1:0] ENTRY = tbl_entry(k, LOG_TABLE_BITS);
    assign tbl[k] = ENTRY;
  end

  logic [E_W-1:0]    e1_d, e1_q, e2_q, e3_q, e4_q;
  logic [NORM_W-1:0] x1_q, f2_d, f2_q;
  logic [E_W-1:0]    sh;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [IDX_W-1:0]  idx_lo, idx_hi;
  logic [TBL_W-1:0]  lo3_q, diff3_d, diff3_q, lo4_q;
  logic [REM_W-1:0]  rem3_q;
  logic [PROD_W-1:0] prod4_d, prod4_q;
  logic [LOG_W-1:0]  log5_d, log5_q;

  // leading one position
  always_comb begin
    e1_d = '0;
    for (int i = 0; i < NORM_W; i++) begin
      if (x_i[i]) begin
        e1_d = E_W'(i);
      end
    end
  end

  // drop the leading one, keep 31 fraction bits
  assign sh   = E_W'(NORM_W) - e1_q;
  assign f2_d = x1_q << sh;

  assign idx     = f2_q[NORM_W-1 -: LOG_TABLE_BITS];
  assign idx_lo  = {1'b0, idx};
  assign idx_hi  = idx_lo + IDX_W'(1);
  assign diff3_d = tbl[idx_hi] - tbl[idx_lo];

  assign prod4_d = PROD_W'(diff3_q) * PROD_W'(rem3_q);

  assign log5_d = {e4_q, {FRAC_BITS{1'b0}}} + LOG_W'(lo4_q)
                + LOG_W'(prod4_q[PROD_W-1:REM_W]);

  always_ff @(posedge clk_i) begin
    x1_q    <= x_i;
    e1_q    <= e1_d;
    f2_q    <= f2_d;
    e2_q    <= e1_q;
    lo3_q   <= tbl[idx_lo];
    diff3_q <= diff3_d;
    rem3_q  <= f2_q[REM_W-1:0];
    e3_q    <= e2_q;
    prod4_q <= prod4_d;
    lo4_q   <= lo3_q;
    e4_q    <= e3_q;
    log5_q  <= log5_d;
  end

  assign log_o = log5_q;

endmodule

`default_nettype wire

// ----- hdl/vrdb_scale.sv -----
// vrdb_scale: difference of two logarithms times 2*log10(2), split multiply,
// round half away from zero and saturate to the q5.16 level range
// depends on: vrdb_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrdb_scale (
  input  wire                                clk_i,
  input  wire  [vrdb_pkg::LOG_W-1:0]         log_v_i,
  input  wire  [vrdb_pkg::LOG_W-1:0]         log_r_i,
  output logic signed [vrdb_pkg::LEVEL_W-1:0] level_o
);
  import vrdb_pkg::*;

  localparam int unsigned D_LO_W = 17;
  localparam int unsigned D_HI_W = LOG_W - D_LO_W;
  localparam int unsigned PLO_W  = D_LO_W + K_W;
  localparam int unsigned PHI_W  = D_HI_W + K_W;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned MAG_W  = 22;
  localparam int unsigned RSH    = 42;

  logic             neg1_q, neg2_q, neg3_q;
  logic [LOG_W-1:0] d1_d, d1_q;
  logic [PLO_W-1:0] plo2_q;
  logic [PHI_W-1:0] phi2_q;
  logic [SUM_W-1:0] sum3;
  logic [MAG_W-1:0] mag3_q;

  assign d1_d = (log_v_i < log_r_i) ? (log_r_i - log_v_i) : (log_v_i - log_r_i);

  assign sum3 = (SUM_W'(phi2_q) << D_LO_W) + SUM_W'(plo2_q)
              + (SUM_W'(1) << (RSH - 1));

  always_ff @(posedge clk_i) begin
    neg1_q <= log_v_i < log_r_i;
    d1_q   <= d1_d;
    neg2_q <= neg1_q;
    plo2_q <= PLO_W'(d1_q[D_LO_W-1:0]) * PLO_W'(K_LOG10_2X2);
    phi2_q <= PHI_W'(d1_q[LOG_W-1:D_LO_W]) * PHI_W'(K_LOG10_2X2);
    neg3_q <= neg2_q;
    mag3_q <= sum3[SUM_W-1 -: MAG_W];
  end

  // saturate, the negative side reaches one step further
  always_comb begin
    if (neg3_q) begin
      if (mag3_q > MAG_W'(1 << (LEVEL_W - 1))) begin
        level_o = LEVEL_MIN;
      end else begin
        level_o = -$signed(mag3_q[LEVEL_W-1:0]);
      end
    end else begin
      if (mag3_q > MAG_W'(LEVEL_MAX)) begin
        level_o = LEVEL_MAX;
      end else begin
        level_o = $signed(mag3_q[LEVEL_W-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/voltage_ratio_to_decibels.sv -----
// voltage_ratio_to_decibels: top level, level = 2*log10(volts/reference)
// in q5.16 from two pipelined base-2 logarithms and a scaling stage
// depends on: vrdb_pkg, vrdb_log2, vrdb_scale
//
//   channel   ports                                      transfer when
//   --------  -----------------------------------------  -------------
//   command   start_i, busy_o, volts_i, reference_i,     start_i & !busy_o
//             last_in_i
//   result    done_o, level_o, status_o, last_out_o      done_o
//
// - one sample is taken every cycle, busy_o stays low
// - a result follows its command transfer through five log2 stages,
//   three scaling stages and the output register
// - rst_ni clears the valid bits of the sideband line and the result strobe;
//   data registers are not reset
// - the receiver cannot stall, so nothing in the pipeline ever waits
`timescale 1ns / 1ps
`default_nettype none

module voltage_ratio_to_decibels #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned LOG_TABLE_BITS = 6
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  output logic                                busy_o,
  input  wire  signed [SAMPLE_WIDTH-1:0]      volts_i,
  input  wire  signed [SAMPLE_WIDTH-1:0]      reference_i,
  input  wire                                 last_in_i,
  output logic                                done_o,
  output logic signed [vrdb_pkg::LEVEL_W-1:0] level_o,
  output logic [1:0]                          status_o,
  output logic                                last_out_o
);
  import vrdb_pkg::*;

  logic [NORM_W-1:0] x_v, x_r;
  logic [LOG_W-1:0]  log_v, log_r;
  logic signed [LEVEL_W-1:0] scaled_level;
  logic signed [LEVEL_W-1:0] level_d, level_q;

  side_t   side_in;
  side_t   side_q [PIPE_DEPTH];
  status_e status_d;
  status_e status_q;
  logic    done_q;
  logic    last_q;

  // fully pipelined, always ready
  assign busy_o = 1'b0;

  // sign and zero checks decide the special cases up front
  always_comb begin
    if (volts_i == '0) begin
      status_d = ST_ZERO;
    end else if (volts_i[SAMPLE_WIDTH-1]) begin
      status_d = ST_NEGATIVE;
    end else if (reference_i == '0 || reference_i[SAMPLE_WIDTH-1]) begin
      status_d = ST_BAD_REF;
    end else begin
      status_d = ST_NORMAL;
    end
  end

  assign side_in.valid  = start_i & ~busy_o;
  assign side_in.last   = last_in_i;
  assign side_in.status = status_d;

  // magnitudes below the sign bit, zero extended to the normalizer width
  assign x_v = NORM_W'(volts_i[SAMPLE_WIDTH-2:0]);
  assign x_r = NORM_W'(reference_i[SAMPLE_WIDTH-2:0]);

  vrdb_log2 #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_log_v (
    .clk_i(clk_i),
    .x_i  (x_v),
    .log_o(log_v)
  );

  vrdb_log2 #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_log_r (
    .clk_i(clk_i),
    .x_i  (x_r),
    .log_o(log_r)
  );

  // the q4.20 scale cancels in the difference
  vrdb_scale u_scale (
    .clk_i  (clk_i),
    .log_v_i(log_v),
    .log_r_i(log_r),
    .level_o(scaled_level)
  );

  // sideband line runs alongside the arithmetic, one entry per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= side_in;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // special cases override the computed level
  always_comb begin
    case (side_q[PIPE_DEPTH-1].status)
      ST_NORMAL: begin
        level_d = scaled_level;
      end
      ST_ZERO: begin
        level_d = LEVEL_ZERO_IN;
      end
      default: begin
        level_d = '0;
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_q[PIPE_DEPTH-1].valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    level_q  <= level_d;
    status_q <= side_q[PIPE_DEPTH-1].status;
    last_q   <= side_q[PIPE_DEPTH-1].last;
  end

  assign done_o     = done_q;
  assign level_o    = level_q;
  assign status_o   = status_q;
  assign last_out_o = last_q;

  // every result traces back to a command transfer a fixed latency earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, PIPE_DEPTH + 1))
    else $error("result strobe without matching command transfer");

  // the block mark travels with its sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> last_out_o == $past(last_in_i, PIPE_DEPTH + 1))
    else $error("last mark out of step with its sample");

  // zero input forces the floor level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_ZERO) |-> level_o == LEVEL_ZERO_IN)
    else $error("zero input did not give the floor level");

  // negative input or bad reference gives zero level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NEGATIVE || status_o == ST_BAD_REF))
      |-> level_o == '0)
    else $error("error status with nonzero level");

endmodule

`default_nettype wire
